// ===== rtl/core/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared constants, request record and helper function.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS  = 32768;
  localparam int BLOCK_BYTES = 4096;
  localparam int WORD_BITS   = 32;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int MAP_WORDS   = MAX_BLOCKS / WORD_BITS;
  localparam int WAW         = $clog2(MAP_WORDS);
  localparam int RNG_W       = $clog2(MAX_BLOCKS) + 1;
  localparam int BOFF_W      = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = 16;
  localparam int ADDR_W      = 32;

  typedef enum logic [1:0] {
    FN_ALLOC     = 2'd0,
    FN_FREE      = 2'd1,
    FN_MARK_FREE = 2'd2,
    FN_MARK_USED = 2'd3
  } func_t;

  // classified request: block range [first, last) and count
  typedef struct packed {
    func_t            func;
    logic [RNG_W-1:0] first;
    logic [RNG_W-1:0] last;
    logic [CNT_W-1:0] count;
  } req_t;

  function automatic logic [RNG_W-1:0] eff_lim(input logic [CNT_W-1:0] total);
    logic [CNT_W:0] t;
    t = {1'b0, total};
    if (t > (CNT_W+1)'(MAX_BLOCKS)) begin
      return RNG_W'(MAX_BLOCKS);
    end
    return RNG_W'(total);
  endfunction

endpackage

// ===== rtl/core/bba_fifo.sv =====
// ----------------------------------------------------------------------------
// Request queue
// Two-entry queue between the classifier and the bitmap engine.
// ----------------------------------------------------------------------------
module bba_fifo import bba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t din,
  output logic full,
  input  logic pop,
  output logic valid,
  output req_t dout
);

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule

// ===== rtl/core/bba_front.sv =====
// ----------------------------------------------------------------------------
// Request front end
// Accepts request beats, turns byte addresses into block ranges and queues
// them for the bitmap engine.
// ----------------------------------------------------------------------------
module bba_front import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [79:0]      in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic [RNG_W-1:0] lim,
  input  logic             hold,
  output logic             q_valid,
  output req_t             q_req,
  input  logic             q_pop
);

  localparam int FB_W = ADDR_W - BOFF_W;
  localparam int SP_W = ADDR_W + 2;

  logic [ADDR_W-1:0] addr, len;
  logic [CNT_W-1:0]  cnt;
  logic [FB_W-1:0]   first_full;
  logic [FB_W:0]     free_end;
  logic [SP_W-1:0]   span;
  logic [SP_W-BOFF_W-1:0] mark_end;
  logic [RNG_W-1:0]  first_c, end_c;
  logic              full, push;
  req_t              req;

  assign addr = in_tdata[31:0];
  assign cnt  = in_tdata[47:32];
  assign len  = in_tdata[79:48];

  always_comb begin
    first_full = addr[ADDR_W-1:BOFF_W];
    free_end   = {1'b0, first_full} + (FB_W+1)'(cnt);
    span       = SP_W'(addr) + SP_W'(len) + SP_W'(BLOCK_BYTES - 1);
    mark_end   = span[SP_W-1:BOFF_W];
    if ({1'b0, first_full} >= (FB_W+1)'(MAX_BLOCKS)) begin
      first_c = RNG_W'(MAX_BLOCKS);
    end else begin
      first_c = RNG_W'(first_full);
    end
    end_c = '0;
    unique case (func_t'(in_tuser))
      FN_FREE: begin
        if (free_end >= (FB_W+1)'(MAX_BLOCKS)) end_c = RNG_W'(MAX_BLOCKS);
        else end_c = RNG_W'(free_end);
      end
      FN_MARK_FREE, FN_MARK_USED: begin
        // zero length leaves an empty range
        if (len == '0) end_c = '0;
        else if (mark_end >= (SP_W-BOFF_W)'(lim)) end_c = lim;
        else end_c = RNG_W'(mark_end);
      end
      default: end_c = '0;
    endcase
    req.func  = func_t'(in_tuser);
    req.first = first_c;
    req.last  = end_c;
    req.count = cnt;
  end

  assign in_tready = !full && !hold;
  assign push      = in_tvalid && in_tready;

  bba_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (req),
    .full  (full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_req)
  );

endmodule

// ===== rtl/core/bba_back.sv =====
// ----------------------------------------------------------------------------
// Bitmap engine
// Holds the usage bitmap and used count, runs the first-fit search word by
// word and applies range updates by read-modify-write.
// ----------------------------------------------------------------------------
module bba_back import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  output logic [RNG_W-1:0] lim,
  output logic             filling,
  input  logic             q_valid,
  input  req_t             q_req,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  output logic [0:0]       out_tuser
);

  typedef enum logic [4:0] {
    ST_FILL   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_RMW    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [WAW-1:0]    ra_r, ra_nxt, pw_r, rd_addr;
  logic              dv_r, dv_nxt;
  logic [RNG_W-1:0]  run_r, run_nxt, rs_r, rs_nxt;
  func_t             op_r, op_nxt;
  logic [RNG_W-1:0]  first_r, first_nxt, last_r, last_nxt, start_r, start_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fail_r, fail_nxt;
  logic              ov_r, ov_nxt, os_r, os_nxt;
  logic [ADDR_W-1:0] oa_r, oa_nxt;
  logic [CNT_W-1:0]  ou_r, ou_nxt;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r, wdata;
  logic                 we;
  logic [WAW-1:0]       wa;

  // search datapath
  logic [RNG_W-1:0]     base, blk, lim_m1, last_m1, s_pos, sum16;
  logic [WAW-1:0]       last_w, lw;
  logic [WORD_BITS-1:0] vm, fr, hits;
  logic [63:0]          pk, rr;
  logic [BIT_W:0]       lead, top, hidx;
  logic [BIT_W-1:0]     pidx;
  logic [RNG_W:0]       run_sum;
  logic                 found_x, found_i, found, int_ok;
  // range update datapath
  logic [RNG_W:0]       lo_d, hi_d;
  logic [BIT_W:0]       lo_off, hi_off;
  logic [WORD_BITS:0]   hi_m;
  logic [WORD_BITS-1:0] lo_m, msk, chg;
  logic [BIT_W:0]       pc;
  logic                 set_mode, rmw_last;
  logic [CNT_W:0]       u_add, avail;

  assign lim     = eff_lim(total_r);
  assign filling = (state_r == ST_FILL);
  assign lim_m1  = lim - RNG_W'(1);
  assign last_w  = lim_m1[RNG_W-2:BIT_W];
  assign base    = RNG_W'({pw_r, BIT_W'(0)});
  assign rd_addr = (state_r == ST_SEARCH || state_r == ST_RMW) ? ra_r : '0;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (we) mem[wa] <= wdata;
  end

  // first-fit word evaluation
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      blk   = base + RNG_W'(i);
      vm[i] = (blk != '0) && (blk < lim);
    end
    fr   = ~rdata_r & vm;
    lead = (BIT_W+1)'(WORD_BITS);
    for (int i = WORD_BITS-1; i >= 0; i--) begin
      if (!fr[i]) lead = (BIT_W+1)'(i);
    end
    hidx = (BIT_W+1)'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!fr[i]) hidx = (BIT_W+1)'(i);
    end
    top = (hidx == (BIT_W+1)'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS)
                                          : (BIT_W+1)'(WORD_BITS - 1) - hidx;
    // positions that open n free bits inside this word
    pk = {32'd0, fr};
    rr = '1;
    for (int k = 0; k <= BIT_W; k++) begin
      if (cnt_r[k]) rr = rr & (pk >> (cnt_r & CNT_W'((1 << k) - 1)));
      pk = pk & (pk >> (1 << k));
    end
    int_ok = (cnt_r <= CNT_W'(WORD_BITS));
    hits   = rr[WORD_BITS-1:0];
    pidx   = '0;
    for (int i = WORD_BITS-1; i >= 0; i--) begin
      if (hits[i]) pidx = BIT_W'(i);
    end
    run_sum = {1'b0, run_r} + (RNG_W+1)'(lead);
    found_x = (run_r != '0) && (run_sum >= (RNG_W+1)'(cnt_r));
    found_i = int_ok && (hits != '0);
    found   = found_x || found_i;
    s_pos   = found_x ? rs_r : base + RNG_W'(pidx);
    sum16   = s_pos + RNG_W'(cnt_r);
  end

  // range mask for read-modify-write
  always_comb begin
    last_m1  = last_r - RNG_W'(1);
    lw       = last_m1[RNG_W-2:BIT_W];
    lo_d     = {1'b0, first_r} - {1'b0, base};
    hi_d     = {1'b0, last_r} - {1'b0, base};
    lo_off   = (first_r > base) ? lo_d[BIT_W:0] : '0;
    hi_off   = (hi_d >= (RNG_W+1)'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS) : hi_d[BIT_W:0];
    hi_m     = ((WORD_BITS+1)'(1) << hi_off) - (WORD_BITS+1)'(1);
    lo_m     = ~((WORD_BITS'(1) << lo_off[BIT_W-1:0]) - WORD_BITS'(1));
    msk      = hi_m[WORD_BITS-1:0] & lo_m;
    set_mode = (op_r == FN_ALLOC) || (op_r == FN_MARK_USED);
    chg      = set_mode ? (msk & ~rdata_r) : (msk & rdata_r);
    pc       = '0;
    for (int i = 0; i < WORD_BITS; i++) pc = pc + (BIT_W+1)'(chg[i]);
    rmw_last = dv_r && (pw_r == lw);
    avail    = {1'b0, lim[CNT_W-1:0]} - {1'b0, used_r};
  end

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    used_nxt  = used_r;
    ra_nxt    = ra_r;
    dv_nxt    = 1'b0;
    run_nxt   = run_r;
    rs_nxt    = rs_r;
    op_nxt    = op_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    fail_nxt  = fail_r;
    ov_nxt    = ov_r;
    os_nxt    = os_r;
    oa_nxt    = oa_r;
    ou_nxt    = ou_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    wa        = pw_r;
    wdata     = set_mode ? (rdata_r | msk) : (rdata_r & ~msk);
    u_add     = '0;

    if (out_tready) ov_nxt = 1'b0;

    unique case (state_r)
      ST_FILL: begin
        we    = 1'b1;
        wa    = ra_r;
        wdata = '1;
        ra_nxt = ra_r + WAW'(1);
        if (ra_r == WAW'(MAP_WORDS - 1)) begin
          used_nxt  = CNT_W'(lim);
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_req.func;
          first_nxt = q_req.first;
          last_nxt  = q_req.last;
          cnt_nxt   = q_req.count;
          fail_nxt  = 1'b0;
          start_nxt = '0;
          if (q_req.func == FN_ALLOC) begin
            if (q_req.count != '0 && used_r <= CNT_W'(lim) &&
                avail >= (CNT_W+1)'(q_req.count)) begin
              run_nxt   = '0;
              rs_nxt    = '0;
              ra_nxt    = WAW'(1);
              state_nxt = ST_SEARCH;
            end else begin
              fail_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end
          end else if (q_req.last > q_req.first) begin
            ra_nxt    = q_req.first[RNG_W-2:BIT_W];
            state_nxt = ST_RMW;
          end else begin
            // empty range; free still drops the count
            if (q_req.func == FN_FREE) begin
              used_nxt = (used_r > q_req.count) ? used_r - q_req.count : '0;
            end
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SEARCH: begin
        ra_nxt = ra_r + WAW'(1);
        if (found) begin
          first_nxt = s_pos;
          last_nxt  = sum16;
          start_nxt = s_pos;
          ra_nxt    = s_pos[RNG_W-2:BIT_W];
          state_nxt = ST_RMW;
        end else if (pw_r == last_w) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else if (fr == '1) begin
          rs_nxt  = (run_r == '0) ? base : rs_r;
          run_nxt = run_r + RNG_W'(WORD_BITS);
        end else begin
          run_nxt = RNG_W'(top);
          rs_nxt  = base + RNG_W'(WORD_BITS) - RNG_W'(top);
        end
      end
      ST_RMW: begin
        ra_nxt = ra_r + WAW'(1);
        dv_nxt = (ra_r <= lw) && !rmw_last;
        if (dv_r) begin
          we = 1'b1;
          if (op_r == FN_MARK_USED) begin
            u_add    = {1'b0, used_r} + (CNT_W+1)'(pc);
            used_nxt = u_add[CNT_W] ? '1 : u_add[CNT_W-1:0];
          end else if (op_r == FN_MARK_FREE) begin
            used_nxt = (used_r > CNT_W'(pc)) ? used_r - CNT_W'(pc) : '0;
          end
          if (rmw_last) begin
            if (op_r == FN_ALLOC) begin
              u_add    = {1'b0, used_r} + {1'b0, cnt_r};
              used_nxt = u_add[CNT_W] ? '1 : u_add[CNT_W-1:0];
            end else if (op_r == FN_FREE) begin
              used_nxt = (used_r > cnt_r) ? used_r - cnt_r : '0;
            end
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          os_nxt    = fail_r;
          oa_nxt    = (fail_r || op_r != FN_ALLOC) ? '0
                      : ADDR_W'(start_r) << BOFF_W;
          ou_nxt    = used_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_wr_en) begin
      total_nxt = cfg_wr_data;
      ra_nxt    = '0;
      state_nxt = ST_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      total_r <= CNT_W'(MAX_BLOCKS);
      used_r  <= '0;
      ra_r    <= '0;
      dv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      used_r  <= used_nxt;
      ra_r    <= ra_nxt;
      dv_r    <= dv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pw_r    <= rd_addr;
    run_r   <= run_nxt;
    rs_r    <= rs_nxt;
    op_r    <= op_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    start_r <= start_nxt;
    cnt_r   <= cnt_nxt;
    fail_r  <= fail_nxt;
    os_r    <= os_nxt;
    oa_r    <= oa_nxt;
    ou_r    <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {ou_r, oa_r};
  assign out_tuser  = os_r;

endmodule

// ===== rtl/core/bitmap_block_allocator.sv =====
// Sequence: a request without bitmap access goes straight to the done state; an
//   allocate scans up to 1024 words, then rewrites its run (up to 1024 more).
// Throughput: one request at a time at one 32-bit bitmap word per cycle.
// Reset: rst_n low clears control; a pass then fills all 1024 map words with
//   ones, with in_tready low. A cfg write starts the same pass.
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit block allocator over a one-bit-per-block usage map.
// ----------------------------------------------------------------------------
module bitmap_block_allocator import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,  // total_blocks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,     // address[31:0], block_count[47:32], region_bytes[79:48]
  input  logic [1:0]  in_tuser,     // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // block_address[31:0], used_count[47:32]
  output logic [0:0]  out_tuser     // status[0]
);

  logic [RNG_W-1:0] lim;
  logic             filling, q_valid, q_pop;
  req_t             q_req;

  bba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .lim       (lim),
    .hold      (filling),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop)
  );

  bba_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .lim         (lim),
    .filling     (filling),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== verif/bba_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Watches the request and response streams, keeps its own copy of the usage
// map and used count, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [0:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        status;
    logic [31:0] block_address;
    logic [15:0] used_count;
  } resp_t;

  logic [MAX_BLOCKS-1:0] usage_map;
  int unsigned           used_cnt;
  int unsigned           total_reg;
  resp_t                 resp_q[$];

  function automatic int unsigned limit_blocks();
    return (total_reg > MAX_BLOCKS) ? MAX_BLOCKS : total_reg;
  endfunction

  function automatic logic blk_is_used(longint unsigned b);
    if (b >= MAX_BLOCKS) return 1'b1;
    return usage_map[b];
  endfunction

  task automatic blk_set(longint unsigned b, logic v);
    if (b < MAX_BLOCKS) usage_map[b] = v;
  endtask

  task automatic fill_map();
    usage_map = '1;
    used_cnt  = limit_blocks();
  endtask

  // Predict the response for one request and advance the model state.
  task automatic predict_request(func_t fn, logic [31:0] addr, logic [15:0] n,
                                 logic [31:0] len);
    longint unsigned lim, b, run, start, first, last;
    logic            found;
    resp_t           r;
    lim   = limit_blocks();
    found = 1'b0;
    start = 0;
    r     = '0;
    case (fn)
      FN_ALLOC: begin
        r.status = 1'b1;
        if (n != 0 && used_cnt <= lim && lim - used_cnt >= n) begin
          b = 1;
          while (!found && b + n <= lim) begin
            run = 0;
            while (run < n && !blk_is_used(b + run)) run++;
            if (run == n) begin
              found = 1'b1;
              start = b;
            end else begin
              b += run + 1;
            end
          end
        end
        if (found) begin
          for (longint unsigned i = 0; i < n; i++) blk_set(start + i, 1'b1);
          used_cnt += n;
          if (used_cnt > 16'hFFFF) used_cnt = 16'hFFFF;
          r.status        = 1'b0;
          r.block_address = 32'(start * BLOCK_BYTES);
        end
      end
      FN_FREE: begin
        first = addr / BLOCK_BYTES;
        for (longint unsigned i = 0; i < n; i++) blk_set(first + i, 1'b0);
        used_cnt = (used_cnt > n) ? used_cnt - n : 0;
      end
      default: begin
        if (len != 0) begin
          first = addr / BLOCK_BYTES;
          last  = (64'(addr) + len + BLOCK_BYTES - 1) / BLOCK_BYTES;
          if (last > lim) last = lim;
          for (b = first; b < last; b++) begin
            if (blk_is_used(b) != (fn == FN_MARK_USED)) begin
              blk_set(b, fn == FN_MARK_USED);
              if (fn == FN_MARK_USED) begin
                if (used_cnt < 16'hFFFF) used_cnt++;
              end else if (used_cnt > 0) begin
                used_cnt--;
              end
            end
          end
        end
      end
    endcase
    r.used_count = 16'(used_cnt);
    resp_q.push_back(r);
  endtask

  assign pending = resp_q.size();

  always @(posedge clk) begin
    resp_t got, exp_r;
    if (!rst_n) begin
      total_reg = 32768;
      fill_map();
      resp_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        total_reg = cfg_wr_data;
        fill_map();
      end
      if (in_tvalid && in_tready)
        predict_request(func_t'(in_tuser), in_tdata[31:0], in_tdata[47:32],
                        in_tdata[79:48]);
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata[31:0], out_tdata[47:32]};
        if (resp_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("ERROR: unexpected response %h", got);
        end else begin
          exp_r = resp_q.pop_front();
          if (got !== exp_r) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"ERROR: status exp %0d got %0d, addr exp %h got %h, ",
                        "used exp %0d got %0d"},
                       exp_r.status, got.status, exp_r.block_address,
                       got.block_address, exp_r.used_count, got.used_count);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_bitmap_block_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives directed and random allocate, free and mark requests under several
// block-count settings with random stalls on both streams; the checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int WATCHDOG = 40000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // address[31:0], block_count[47:32], region_bytes[79:48]
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // block_address[31:0], used_count[47:32]
  logic [0:0]  out_tuser;  // status[0]
  int          fail_count;
  int          pending;
  int          idle_cycles;
  logic        hold_off;
  logic        sending;

  bitmap_block_allocator dut (.*);

  bba_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Receiver: random stalls, plus one long hold-off while requests pile up.
  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      out_tready <= 1'b1;
      @(posedge clk);
      g = ($urandom_range(3) == 0) ? 0 : gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send_req(func_t fn, logic [31:0] addr, logic [15:0] n, logic [31:0] len);
    int g;
    g = sending ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, n, addr};
    in_tuser  <= fn;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_total(logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small sizes around the managed range, occasionally huge fields.
  task automatic random_req(int unsigned lim);
    func_t       fn;
    logic [31:0] addr, len;
    logic [15:0] n;
    fn   = func_t'(2'($urandom_range(3)));
    addr = $urandom_range(lim + 2) * BLOCK_BYTES
           + (($urandom_range(3) == 0) ? $urandom_range(4095) : 0);
    n    = 16'($urandom_range(12));
    len  = $urandom_range(12) * BLOCK_BYTES + $urandom_range(1) * $urandom_range(4095);
    if ($urandom_range(15) == 0) addr = $urandom;
    if ($urandom_range(15) == 0) n = 16'($urandom);
    if ($urandom_range(15) == 0) len = $urandom;
    send_req(fn, addr, n, len);
  endtask

  task automatic report();
    if (fail_count == 0)
      $display("tb_bitmap_block_allocator: done, clean");
    else
      $display("tb_bitmap_block_allocator: done, errors");
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = FN_ALLOC;
    hold_off    = 1'b0;
    sending     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // map full after reset: the first allocates fail until a mark-free clears the map
    send_req(FN_ALLOC, 0, 0, 0);
    send_req(FN_ALLOC, 0, 1, 0);
    send_req(FN_MARK_FREE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    send_req(FN_MARK_FREE, 0, 0, 32'hFFFF_FFFF);
    send_req(FN_ALLOC, 0, 16'hFFFF, 0);
    send_req(FN_ALLOC, 0, 16'd32767, 0);
    send_req(FN_ALLOC, 0, 16'd32768, 0);
    send_req(FN_MARK_USED, 32'h0000_1FFF, 16'd1, 32'd1);
    send_req(FN_ALLOC, 0, 3, 0);
    send_req(FN_FREE, 32'hFFFF_F000, 16'hFFFF, 0);
    send_req(FN_FREE, 32'h0000_4000, 16'hFFFF, 0);
    send_req(FN_MARK_USED, 32'h0, 0, 32'h0);
    write_total(16'd0);
    send_req(FN_ALLOC, 0, 1, 0);
    send_req(FN_FREE, 0, 5, 0);
    send_req(FN_MARK_USED, 0, 0, 32'h8000);
    write_total(16'hFFFF);
    send_req(FN_MARK_FREE, 32'h1000, 0, 32'h5000);
    send_req(FN_ALLOC, 0, 6, 0);
    send_req(FN_ALLOC, 0, 5, 0);
    send_req(FN_FREE, 32'h1FFF, 2, 0);
    send_req(FN_ALLOC, 0, 2, 0);
    write_total(16'd40);
    send_req(FN_MARK_FREE, 0, 0, 32'hFFFF_F000);
    send_req(FN_ALLOC, 0, 39, 0);
    sending = 1'b1;
    for (int phase = 0; phase < 5; phase++) begin
      int unsigned lim;
      case (phase)
        0: lim = 64;
        1: lim = 1;
        2: lim = 200;
        3: lim = 33;
        default: lim = 96;
      endcase
      write_total(16'(lim));
      send_req(FN_MARK_FREE, 0, 0, 32'hFFFF_FFFF);
      if (phase == 2) hold_off = 1'b1;
      for (int i = 0; i < 85; i++) random_req(lim);
    end
    drain();
    report();
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG) begin
      $display("tb_bitmap_block_allocator: done, errors");
      $finish;
    end
  end

endmodule

// ===== bitmap_block_allocator.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_fifo.sv
rtl/core/bba_front.sv
rtl/core/bba_back.sv
rtl/core/bitmap_block_allocator.sv
verif/bba_checker.sv
verif/tb_bitmap_block_allocator.sv
